// ===== design/dsv_pkg.sv =====
// shared constants and the month length table for the date string validator
package dsv_pkg;

   localparam int unsigned CHAR_WIDTH  = 8;
   localparam int unsigned YEAR_WIDTH  = 14;
   localparam int unsigned FIELD_WIDTH = 7;
   localparam int unsigned POS_WIDTH   = 4;

   localparam logic [CHAR_WIDTH-1:0] CHAR_DASH = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE = 8'h39;

   localparam logic [POS_WIDTH-1:0] POS_CENTURY_END = 4'd2;
   localparam logic [POS_WIDTH-1:0] POS_DASH_YEAR   = 4'd4;
   localparam logic [POS_WIDTH-1:0] POS_DASH_MONTH  = 4'd7;
   localparam logic [POS_WIDTH-1:0] POS_FINAL       = 4'd9;
   localparam logic [POS_WIDTH-1:0] POS_LENGTH      = 4'd10;
   localparam logic [POS_WIDTH-1:0] POS_SATURATE    = 4'd15;

   localparam logic [YEAR_WIDTH-1:0]  MIN_YEAR           = 14'd1900;
   localparam logic [YEAR_WIDTH-1:0]  CURRENT_YEAR_RESET = 14'd2024;
   localparam logic [FIELD_WIDTH-1:0] MONTH_MIN          = 7'd1;
   localparam logic [FIELD_WIDTH-1:0] MONTH_MAX          = 7'd12;
   localparam logic [FIELD_WIDTH-1:0] MONTH_FEB          = 7'd2;
   localparam logic [FIELD_WIDTH-1:0] DAY_MIN            = 7'd1;
   localparam logic [FIELD_WIDTH-1:0] DAY_LEAP           = 7'd29;

   typedef logic [CHAR_WIDTH-1:0]  char_type;
   typedef logic [YEAR_WIDTH-1:0]  year_type;
   typedef logic [FIELD_WIDTH-1:0] field_type;
   typedef logic [POS_WIDTH-1:0]   pos_type;

   function automatic field_type month_length(input field_type month);
      field_type len;
      unique case (month)
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 7'd31;
         7'd4, 7'd6, 7'd9, 7'd11:                   len = 7'd30;
         7'd2:                                      len = 7'd28;
         default:                                   len = 7'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== design/date_string_validator.sv =====
// top level: streams YYYY-MM-DD characters and flags valid calendar dates
// a result is registered in the output register when the last beat leaves the input register
// throughput: one character beat per cycle, set by the single input and result register pair
// a result waiting under stall blocks only the next last beat, other beats keep flowing
// reset: synchronous, active high; clears the string state and sets current year to 2024
module date_string_validator (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  dsv_pkg::char_type       req_character,
   input  logic                    req_last,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_valid_res,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  dsv_pkg::year_type       csr_current_year
);
   import dsv_pkg::*;

   year_type  cur_year_ff;

   logic      s1_valid_ff, s1_valid_in;
   char_type  s1_char_ff;
   logic      s1_last_ff;

   pos_type   position_ff, position_in, position_step;
   year_type  year_accum_ff, year_accum_in, year_accum_step;
   field_type month_accum_ff, month_accum_in, month_accum_step;
   field_type day_accum_ff, day_accum_in, day_accum_step;
   logic      format_error_ff, format_error_in, format_error_step;
   logic [1:0] hi_mod4_ff, hi_mod4_in, hi_mod4_step;
   logic [1:0] lo_mod4_ff, lo_mod4_in, lo_mod4_step;
   logic      lo_nonzero_ff, lo_nonzero_in, lo_nonzero_step;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_valid_res_ff, rsp_valid_res_in;

   logic      out_free;
   logic      advance;
   logic      is_digit;
   logic [3:0] digit_val;
   logic      leap;
   logic      date_ok;
   logic      result;

   // configuration beat
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_year_ff <= CURRENT_YEAR_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            cur_year_ff <= csr_current_year;
         end
      end
   end

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall = s1_valid_ff && !advance;
   assign s1_valid_in = (req_valid && !req_stall) || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_char_ff <= req_character;
         s1_last_ff <= req_last;
      end
   end

   // per character step
   always_comb begin
      is_digit  = (s1_char_ff >= CHAR_ZERO) && (s1_char_ff <= CHAR_NINE);
      digit_val = 4'(s1_char_ff - CHAR_ZERO);

      position_step     = position_ff;
      year_accum_step   = year_accum_ff;
      month_accum_step  = month_accum_ff;
      day_accum_step    = day_accum_ff;
      format_error_step = format_error_ff;
      hi_mod4_step      = hi_mod4_ff;
      lo_mod4_step      = lo_mod4_ff;
      lo_nonzero_step   = lo_nonzero_ff;

      if (position_ff >= POS_LENGTH) begin
         format_error_step = 1'b1;
      end else if (position_ff == POS_DASH_YEAR || position_ff == POS_DASH_MONTH) begin
         if (s1_char_ff != CHAR_DASH) begin
            format_error_step = 1'b1;
         end
      end else if (!is_digit) begin
         format_error_step = 1'b1;
      end else if (position_ff < POS_DASH_YEAR) begin
         year_accum_step = YEAR_WIDTH'(year_accum_ff * 14'd10 + YEAR_WIDTH'(digit_val));
         // (10 * x + d) mod 4 == (2 * x + d) mod 4
         if (position_ff < POS_CENTURY_END) begin
            hi_mod4_step = 2'({hi_mod4_ff[0], 1'b0} + digit_val[1:0]);
         end else begin
            lo_mod4_step    = 2'({lo_mod4_ff[0], 1'b0} + digit_val[1:0]);
            lo_nonzero_step = lo_nonzero_ff || (digit_val != 4'd0);
         end
      end else if (position_ff < POS_DASH_MONTH) begin
         month_accum_step = FIELD_WIDTH'(month_accum_ff * 7'd10 + FIELD_WIDTH'(digit_val));
      end else begin
         day_accum_step = FIELD_WIDTH'(day_accum_ff * 7'd10 + FIELD_WIDTH'(digit_val));
      end

      if (position_ff != POS_SATURATE) begin
         position_step = position_ff + 4'd1;
      end
   end

   // date check on the completed fields
   always_comb begin
      leap    = (lo_mod4_ff == 2'd0) && (lo_nonzero_ff || (hi_mod4_ff == 2'd0));
      date_ok = 1'b0;
      if (year_accum_ff >= MIN_YEAR && year_accum_ff <= cur_year_ff
          && month_accum_ff >= MONTH_MIN && month_accum_ff <= MONTH_MAX) begin
         if (day_accum_step >= DAY_MIN && day_accum_step <= month_length(month_accum_ff)) begin
            date_ok = 1'b1;
         end else if (month_accum_ff == MONTH_FEB && day_accum_step == DAY_LEAP && leap) begin
            date_ok = 1'b1;
         end
      end
      result = (position_ff == POS_FINAL) && !format_error_step && date_ok;
   end

   // next state
   always_comb begin
      position_in     = position_ff;
      year_accum_in   = year_accum_ff;
      month_accum_in  = month_accum_ff;
      day_accum_in    = day_accum_ff;
      format_error_in = format_error_ff;
      hi_mod4_in      = hi_mod4_ff;
      lo_mod4_in      = lo_mod4_ff;
      lo_nonzero_in   = lo_nonzero_ff;
      if (advance) begin
         if (s1_last_ff) begin
            position_in     = '0;
            year_accum_in   = '0;
            month_accum_in  = '0;
            day_accum_in    = '0;
            format_error_in = 1'b0;
            hi_mod4_in      = '0;
            lo_mod4_in      = '0;
            lo_nonzero_in   = 1'b0;
         end else begin
            position_in     = position_step;
            year_accum_in   = year_accum_step;
            month_accum_in  = month_accum_step;
            day_accum_in    = day_accum_step;
            format_error_in = format_error_step;
            hi_mod4_in      = hi_mod4_step;
            lo_mod4_in      = lo_mod4_step;
            lo_nonzero_in   = lo_nonzero_step;
         end
      end

      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_valid_res_in = rsp_valid_res_ff;
      if (advance && s1_last_ff) begin
         rsp_valid_in     = 1'b1;
         rsp_valid_res_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         position_ff     <= '0;
         year_accum_ff   <= '0;
         month_accum_ff  <= '0;
         day_accum_ff    <= '0;
         format_error_ff <= 1'b0;
         hi_mod4_ff      <= '0;
         lo_mod4_ff      <= '0;
         lo_nonzero_ff   <= 1'b0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         position_ff     <= position_in;
         year_accum_ff   <= year_accum_in;
         month_accum_ff  <= month_accum_in;
         day_accum_ff    <= day_accum_in;
         format_error_ff <= format_error_in;
         hi_mod4_ff      <= hi_mod4_in;
         lo_mod4_ff      <= lo_mod4_in;
         lo_nonzero_ff   <= lo_nonzero_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_valid_res_ff <= rsp_valid_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_valid_res_ff;

`ifndef ASSERT_OFF
   // a new result only ever follows a last beat leaving the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && s1_last_ff))
      else $error("result without a last beat");

   // the string state is cleared once a last beat is done
   assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (position_ff == '0 && !format_error_ff))
      else $error("string state not cleared");

   // a last beat of a short or long string never yields a pass
   assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff && position_ff != POS_FINAL) |=> !rsp_valid_res_ff)
      else $error("wrong length passed");

   // the input only backs up behind a held result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall))
      else $error("unexpected input stall");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// testbench for date_string_validator: date strings driven as character beats
module tb;
   import dsv_pkg::*;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BEATS   = 205;

   typedef struct packed {
      char_type character;
      logic     last;
   } char_beat_type;

   typedef enum {FLOW_FREE, FLOW_RANDOM, FLOW_PERIODIC, FLOW_CHOKED} stall_mode_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   char_type req_character = '0;
   logic     req_last = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   logic     rsp_valid_res;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   year_type csr_current_year = CURRENT_YEAR_RESET;

   date_string_validator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_character    (req_character),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_valid_res    (rsp_valid_res),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_current_year (csr_current_year)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   char_beat_type  text_queue [$];
   char_type       draft [$];
   bit             verdict_queue [$];
   int             beats_queued = 0;
   int             results_seen = 0;
   int             error_count = 0;
   int             cycle_count = 0;
   logic           req_taken = 1'b0;
   bit             steady_flow = 1'b0;
   int             gap_left = 0;
   int             burst_left = 0;
   int             hold_left = 0;
   int             hold_mark = 40;
   int             stall_span = 0;
   stall_mode_type stall_mode = FLOW_FREE;

   year_type  year_limit = CURRENT_YEAR_RESET;
   pos_type   scan_pos = '0;
   year_type  year_sum = '0;
   field_type month_sum = '0;
   field_type day_sum = '0;
   bit        format_bad = 1'b0;

   function automatic bit is_leap(input year_type y);
      return (y % 14'd4 == 0) && ((y % 14'd100 != 0) || (y % 14'd400 == 0));
   endfunction

   // odd months are long up to july, even months from august
   function automatic field_type days_in(input field_type m);
      if (m == MONTH_FEB) return 7'd28;
      return 7'd30 + ((m + (m >> 3)) & 7'd1);
   endfunction

   function automatic bit calendar_ok(input year_type y, input field_type m, input field_type d);
      if (y < MIN_YEAR || y > year_limit) return 1'b0;
      if (m < MONTH_MIN || m > MONTH_MAX) return 1'b0;
      if (d >= DAY_MIN && d <= days_in(m)) return 1'b1;
      return m == MONTH_FEB && d == DAY_LEAP && is_leap(y);
   endfunction

   task automatic advance_date(input char_type c, input logic fin);
      pos_type  p;
      bit       is_digit;
      char_type dv;
      p = scan_pos;
      is_digit = c >= CHAR_ZERO && c <= CHAR_NINE;
      dv = c - CHAR_ZERO;
      if (p >= POS_LENGTH) begin
         format_bad = 1'b1;
      end else if (p == POS_DASH_YEAR || p == POS_DASH_MONTH) begin
         if (c != CHAR_DASH) format_bad = 1'b1;
      end else if (!is_digit) begin
         format_bad = 1'b1;
      end else if (p < POS_DASH_YEAR) begin
         year_sum = year_sum * 14'd10 + dv;
      end else if (p < POS_DASH_MONTH) begin
         month_sum = month_sum * 7'd10 + dv;
      end else begin
         day_sum = day_sum * 7'd10 + dv;
      end
      if (scan_pos != POS_SATURATE) scan_pos = scan_pos + 1'b1;
      if (fin) begin
         verdict_queue.push_back(p == POS_FINAL && !format_bad
                                 && calendar_ok(year_sum, month_sum, day_sum));
         scan_pos = '0;
         year_sum = '0;
         month_sum = '0;
         day_sum = '0;
         format_bad = 1'b0;
      end
   endtask

   // beat acceptance, prediction and result checking
   always @(posedge clock) begin : watch_beats
      bit want;
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) advance_date(req_character, req_last);
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (verdict_queue.size() == 0) begin
               error_count++;
               $display("%0t: valid_res expected none, got %b", $time, rsp_valid_res);
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_valid_res !== want) begin
                  error_count++;
                  $display("%0t: valid_res expected %b, got %b", $time, want, rsp_valid_res);
               end
            end
         end
      end
   end

   always @(negedge clock) begin : drive_beats
      logic offer;
      offer = req_valid;
      if (req_valid && req_taken) begin
         void'(text_queue.pop_front());
         offer = 1'b0;
      end
      if (!offer && !reset && text_queue.size() > 0) begin
         if (gap_left > 0) begin
            gap_left--;
         end else begin
            offer = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = steady_flow ? 0 : $urandom_range(0, 6);
            end
         end
      end
      req_valid <= offer;
      if (offer) begin
         req_character <= text_queue[0].character;
         req_last <= text_queue[0].last;
      end
   end

   always @(negedge clock) begin : drive_stall
      logic hold_now;
      if (hold_left == 0 && results_seen >= hold_mark) begin
         hold_left = 320;
         hold_mark = hold_mark + 90;
      end
      if (stall_span == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_span = $urandom_range(16, 80);
      end else begin
         stall_span--;
      end
      if (hold_left > 0) begin
         hold_left--;
         hold_now = 1'b1;
      end else begin
         case (stall_mode)
            FLOW_FREE:     hold_now = 1'b0;
            FLOW_RANDOM:   hold_now = 1'($urandom_range(0, 1));
            FLOW_PERIODIC: hold_now = (stall_span % 3 == 0);
            default:       hold_now = ($urandom_range(0, 3) != 0);
         endcase
      end
      rsp_stall <= hold_now;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic draft_from(input string s);
      draft.delete();
      for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
   endtask

   task automatic commit_draft;
      char_beat_type b;
      foreach (draft[i]) begin
         b.character = draft[i];
         b.last = (i == draft.size() - 1);
         text_queue.push_back(b);
      end
      beats_queued += draft.size();
      draft.delete();
   endtask

   task automatic queue_date(input string s);
      draft_from(s);
      commit_draft;
   endtask

   task automatic random_date_text;
      int y;
      int m;
      int d;
      int k;
      case ($urandom_range(0, 4))
         0: y = $urandom_range(0, 9999);
         1: begin
            y = int'(year_limit) + int'($urandom_range(0, 4)) - 2;
            if (y < 0) y = 0;
            if (y > 9999) y = 9999;
         end
         2: y = $urandom_range(1898, 1902);
         3: y = $urandom_range(0, 1) ? 4 * $urandom_range(475, 2499) : 100 * $urandom_range(18, 99);
         default: y = $urandom_range(1900, 2100);
      endcase
      case ($urandom_range(0, 9))
         0: m = $urandom_range(0, 99);
         1: m = $urandom_range(0, 1) ? 0 : 13;
         default: m = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 9))
         0: d = $urandom_range(0, 99);
         1, 2, 3, 4: d = $urandom_range(28, 32);
         5: d = $urandom_range(0, 1);
         default: d = $urandom_range(1, 31);
      endcase
      draft_from($sformatf("%04d-%02d-%02d", y, m, d));
      if ($urandom_range(0, 99) >= 80) begin
         case ($urandom_range(0, 3))
            0: draft[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
            1: begin
               k = $urandom_range(1, 9);
               while (draft.size() > k) void'(draft.pop_back());
            end
            2: repeat ($urandom_range(1, 8)) draft.push_back(8'($urandom_range(0, 255)));
            default: begin
               draft.delete();
               repeat ($urandom_range(1, 18)) draft.push_back(8'($urandom_range(0, 255)));
            end
         endcase
      end
      commit_draft;
   endtask

   task automatic wait_idle;
      while (text_queue.size() != 0 || req_valid || verdict_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_year_limit(input year_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_current_year <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      year_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int goal;
      int limit_plan [7] = '{9999, 1900, 1899, 0, 16383, 0, 2024};
      limit_plan[5] = $urandom_range(1900, 9999);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_date("2024-02-29");
      queue_date("2000-02-29");
      queue_date("1900-02-29");
      queue_date("2023-02-29");
      queue_date("1900-01-01");
      queue_date("2024-12-31");
      queue_date("1899-12-31");
      queue_date("2025-01-01");
      queue_date("2024-04-31");
      queue_date("2024-00-10");
      queue_date("2024-13-01");
      queue_date("2024-01-00");
      queue_date("9999-99-99");
      queue_date("0000-00-00");
      queue_date("2024-1-01");
      queue_date("2024-01-011");
      queue_date("2024-01-01-2024-01-01");
      queue_date("2024/01-01");
      queue_date("2024-0a-01");
      queue_date("20-4-01-01");
      queue_date("2024-01-01");
      draft.push_back(8'hFF);
      commit_draft;
      draft.push_back(8'h00);
      commit_draft;

      goal = PHASE_BEATS;
      while (beats_queued < goal) random_date_text;
      wait_idle;

      foreach (limit_plan[i]) begin
         write_year_limit(YEAR_WIDTH'(limit_plan[i]));
         steady_flow = (i % 2 == 1);
         goal += PHASE_BEATS;
         while (beats_queued < goal) random_date_text;
         wait_idle;
      end

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
